FILE: src/bpsdp_pkg.sv
`timescale 1ns / 1ps

package bpsdp_pkg;

    localparam int MAX_PERSONS = 16;
    localparam int W_W         = 30;
    localparam int RIDES_W     = 5;
    localparam int CNT_W       = $clog2(MAX_PERSONS + 1);
    localparam int IDX_W       = (MAX_PERSONS > 1) ? $clog2(MAX_PERSONS) : 1;
    localparam int TBL_DEPTH   = 1 << MAX_PERSONS;
    localparam int CAP_RESET   = 1000;

    typedef struct packed {
        logic [W_W-1:0] person_weight;
        logic           last_person;
    } t_in;

    typedef struct packed {
        logic [RIDES_W-1:0] ride_count;
        logic               overflowed;
    } t_out;

    typedef struct packed {
        logic [RIDES_W-1:0] rides;
        logic [W_W-1:0]     load;
    } t_pair;

    typedef struct packed {
        logic             go;
        logic [CNT_W-1:0] n;
        logic [W_W-1:0]   cap;
    } t_core_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [RIDES_W-1:0] rides;
    } t_core_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ISSUE,
        S_DRAIN1,
        S_DRAIN2,
        S_WRITE,
        S_DONE
    } t_state;

endpackage

FILE: src/bpsdp_core.sv
`timescale 1ns / 1ps

module bpsdp_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bpsdp_pkg::t_core_req        i_req,
    input  logic [bpsdp_pkg::W_W-1:0]   i_weight,
    output logic [bpsdp_pkg::IDX_W-1:0] o_widx,
    output bpsdp_pkg::t_core_rsp        o_rsp
);
    import bpsdp_pkg::*;

    t_state r_state, n_state;

    logic [MAX_PERSONS-1:0] r_mask;
    logic [MAX_PERSONS-1:0] r_full;
    logic [IDX_W-1:0]       r_i;
    logic                   r_s1_vld;
    logic [W_W-1:0]         r_s1_w;
    logic                   r_s2_vld;
    t_pair                  r_cand;
    t_pair                  r_best;
    t_pair                  r_rdata;

    t_pair mem [TBL_DEPTH];

    logic                   w_we;
    logic [MAX_PERSONS-1:0] w_waddr;
    t_pair                  w_wdata;
    logic [MAX_PERSONS-1:0] w_raddr;
    logic                   w_last_i;
    logic [MAX_PERSONS:0]   w_full_wide;
    logic [W_W:0]           w_sum;
    logic                   w_fits;
    t_pair                  w_cand;
    t_pair                  w_start;

    assign w_last_i    = (r_i == IDX_W'(i_req.n - CNT_W'(1)));
    assign w_full_wide = ((MAX_PERSONS+1)'(1) << i_req.n) - (MAX_PERSONS+1)'(1);
    assign w_start     = '{rides: RIDES_W'(i_req.n), load: i_req.cap};
    assign w_raddr     = r_mask ^ (MAX_PERSONS'(1) << r_i);
    assign o_widx      = r_i;

    // The member either joins the last ride or opens a new one.
    assign w_sum  = {1'b0, r_rdata.load} + {1'b0, r_s1_w};
    assign w_fits = (w_sum <= {1'b0, i_req.cap});
    always_comb begin
        if (w_fits) begin
            w_cand = '{rides: r_rdata.rides, load: w_sum[W_W-1:0]};
        end else begin
            w_cand = '{rides: r_rdata.rides + RIDES_W'(1), load: r_s1_w};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_req.go) n_state = S_INIT;
            S_INIT:   n_state = S_ISSUE;
            S_ISSUE:  if (w_last_i) n_state = S_DRAIN1;
            S_DRAIN1: n_state = S_DRAIN2;
            S_DRAIN2: n_state = S_WRITE;
            S_WRITE:  n_state = (r_mask == r_full) ? S_DONE : S_ISSUE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_mask;
        w_wdata = r_best;
        unique case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = '{rides: RIDES_W'(1), load: '0};
            end
            S_WRITE: w_we = 1'b1;
            default: w_we = 1'b0;
        endcase
    end

    assign o_rsp.busy  = (r_state != S_IDLE);
    assign o_rsp.done  = (r_state == S_DONE);
    assign o_rsp.rides = r_best.rides;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_mask   <= '0;
            r_full   <= '0;
            r_i      <= '0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= (r_state == S_ISSUE) && r_mask[r_i];
            r_s2_vld <= r_s1_vld;
            if (r_state == S_INIT) begin
                r_mask <= MAX_PERSONS'(1);
                r_full <= w_full_wide[MAX_PERSONS-1:0];
                r_i    <= '0;
            end
            if (r_state == S_ISSUE) begin
                r_i <= w_last_i ? '0 : r_i + IDX_W'(1);
            end
            if (r_state == S_WRITE && r_mask != r_full) begin
                r_mask <= r_mask + MAX_PERSONS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_w <= i_weight;
        r_cand <= w_cand;
        if (r_state == S_INIT || (r_state == S_WRITE && r_mask != r_full)) begin
            r_best <= w_start;
        end else if (r_s2_vld && (r_cand < r_best)) begin
            r_best <= r_cand;
        end
    end

endmodule

FILE: src/bin_packing_subset_dp.sv
`timescale 1ns / 1ps
// A weight without the last mark is taken without making the block busy, so start may follow at once.
// A weight with the last mark starts a search over every subset of the n stored weights,
// paced by the single table read port and the one shared add and compare unit.
// The result strobe is high for one cycle; the receiver cannot stall it.
// Reset is synchronous and active low: it clears the count, the overflow flag and the
// sequencer and sets the ride capacity to 1000; the weight store and table are not cleared.

module bin_packing_subset_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  bpsdp_pkg::t_in            i_in,
    output logic                      o_done,
    output bpsdp_pkg::t_out           o_out,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [bpsdp_pkg::W_W-1:0] i_cfg_data
);
    import bpsdp_pkg::*;

    logic [W_W-1:0]   r_cap;
    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic [W_W-1:0]   r_wstore [MAX_PERSONS];

    logic             w_accept;
    logic [IDX_W-1:0] w_widx;
    t_core_req        w_req;
    t_core_rsp        w_rsp;

    assign o_cfg_ready = 1'b1;
    assign busy        = w_rsp.busy;
    assign w_accept    = start && !w_rsp.busy;

    assign w_req.go  = w_accept && i_in.last_person;
    assign w_req.n   = r_count;
    assign w_req.cap = r_cap;

    assign o_done           = w_rsp.done;
    assign o_out.ride_count = w_rsp.rides;
    assign o_out.overflowed = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= W_W'(CAP_RESET);
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (w_rsp.done) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (w_accept) begin
                if (r_count < CNT_W'(MAX_PERSONS)) begin
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (r_count < CNT_W'(MAX_PERSONS))) begin
            r_wstore[r_count[IDX_W-1:0]] <= i_in.person_weight;
        end
    end

    bpsdp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_weight (r_wstore[w_widx]),
        .o_widx   (w_widx),
        .o_rsp    (w_rsp)
    );

endmodule

FILE: src/bpsdp_chk.sv
`timescale 1ns / 1ps

module bpsdp_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input bpsdp_pkg::t_in            i_in,
    input logic                      o_done,
    input bpsdp_pkg::t_out           o_out
);
    import bpsdp_pkg::*;

    // A result beat only appears while a batch is being worked on.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result beat outside a batch");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result beat longer than one cycle");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_in.last_person) |=> busy)
        else $error("last weight did not start the search");

    a_plain_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_in.last_person) |=> !busy)
        else $error("plain weight made the block busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_out.ride_count != '0
                    && o_out.ride_count <= RIDES_W'(MAX_PERSONS)))
        else $error("ride count out of range");

endmodule

bind bin_packing_subset_dp bpsdp_chk u_bpsdp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_in        (i_in),
    .o_done      (o_done),
    .o_out       (o_out)
);

FILE: dv/bpsdp_checker.sv
`timescale 1ns / 1ps

module bpsdp_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  bpsdp_pkg::t_in            i_in,
    input  logic                      i_done,
    input  bpsdp_pkg::t_out           i_out,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [bpsdp_pkg::W_W-1:0] i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked
);
    import bpsdp_pkg::*;

    logic [W_W-1:0]         ride_cap;
    logic [W_W-1:0]         weights [MAX_PERSONS];
    int unsigned            stored;
    logic                   dropped;
    logic [RIDES_W+W_W-1:0] best_pair [TBL_DEPTH];
    t_out                   rides_due [$];
    t_out                   want;
    int                     mismatches;
    int                     checked;

    // Fewest rides for the stored weights, built up over every subset of them.
    function automatic t_out solve_batch();
        int unsigned            full;
        int unsigned            mask;
        int unsigned            i;
        logic [RIDES_W+W_W-1:0] best;
        logic [RIDES_W+W_W-1:0] prev;
        logic [RIDES_W+W_W-1:0] cand;
        logic [W_W:0]           sum;
        t_out                   res;
        full = (32'd1 << stored) - 1;
        best_pair[0] = {RIDES_W'(1), W_W'(0)};
        for (mask = 1; mask <= full; mask++) begin
            best = {RIDES_W'(stored), ride_cap};
            for (i = 0; i < stored; i++) begin
                if (mask[i]) begin
                    prev = best_pair[MAX_PERSONS'(mask ^ (32'd1 << i))];
                    sum  = {1'b0, prev[W_W-1:0]} + {1'b0, weights[IDX_W'(i)]};
                    if (sum <= {1'b0, ride_cap}) begin
                        cand = {prev[RIDES_W+W_W-1:W_W], sum[W_W-1:0]};
                    end else begin
                        cand = {prev[RIDES_W+W_W-1:W_W] + RIDES_W'(1),
                                weights[IDX_W'(i)]};
                    end
                    if (cand < best) begin
                        best = cand;
                    end
                end
            end
            best_pair[MAX_PERSONS'(mask)] = best;
        end
        res.ride_count = best_pair[MAX_PERSONS'(full)][RIDES_W+W_W-1:W_W];
        res.overflowed = dropped;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ride_cap   = W_W'(CAP_RESET);
            stored     = 0;
            dropped    = 1'b0;
            mismatches = 0;
            checked    = 0;
            rides_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                ride_cap = i_cfg_data;
            end
            if (i_start && !i_busy) begin
                if (stored < MAX_PERSONS) begin
                    weights[IDX_W'(stored)] = i_in.person_weight;
                    stored++;
                end else begin
                    dropped = 1'b1;
                end
                if (i_in.last_person) begin
                    rides_due.insert(rides_due.size(), solve_batch());
                    stored  = 0;
                    dropped = 1'b0;
                end
            end
            if (i_done) begin
                if (rides_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result beat: rides=%0d overflow=%0b",
                                 i_out.ride_count, i_out.overflowed);
                    end
                end else begin
                    want = rides_due.pop_front();
                    checked++;
                    if (i_out.ride_count !== want.ride_count ||
                        i_out.overflowed !== want.overflowed) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result mismatch: expected rides=%0d overflow=%0b, %s%0d %s%0b",
                                     want.ride_count, want.overflowed,
                                     "got rides=", i_out.ride_count,
                                     "overflow=", i_out.overflowed);
                        end
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= rides_due.size();
        o_checked    <= checked;
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import bpsdp_pkg::*;

    localparam logic [W_W-1:0] WEIGHT_MAX = '1;
    localparam int unsigned    LIMIT      = 8_000_000;

    logic           i_clk     = 1'b0;
    logic           i_rst_n   = 1'b0;
    logic           start     = 1'b0;
    logic           busy;
    t_in            in_beat   = '0;
    logic           done;
    t_out           out_beat;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [W_W-1:0] cfg_data  = '0;

    int             fail_count;
    int             pending;
    int             checked;
    int unsigned    cycles    = 0;
    int unsigned    beats     = 0;
    int unsigned    batches   = 0;
    int unsigned    configs   = 0;
    logic           steady    = 1'b0;

    bin_packing_subset_dp uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (in_beat),
        .o_done      (done),
        .o_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    bpsdp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_in         (in_beat),
        .i_done       (done),
        .i_out        (out_beat),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("bin_packing_subset_dp test failed");
            $finish;
        end
    end

    task automatic idle(int unsigned n);
        repeat (n) @(posedge i_clk);
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [W_W-1:0] pick_weight(logic [W_W-1:0] cap);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return W_W'($urandom_range(1, WEIGHT_MAX));
        end else if (r == 1) begin
            return cap;
        end else if (r == 2) begin
            return 1;
        end else if (r == 3 && cap < WEIGHT_MAX) begin
            return cap + 1'b1;
        end
        return W_W'($urandom_range(1, cap));
    endfunction

    function automatic logic [W_W-1:0] pick_capacity();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 1;
        end else if (r == 1) begin
            return WEIGHT_MAX;
        end else if (r < 4) begin
            return W_W'($urandom_range(1, WEIGHT_MAX));
        end
        return W_W'($urandom_range(2, 5000));
    endfunction

    function automatic int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 4);
        end else if (r < 95) begin
            return $urandom_range(5, 7);
        end
        return $urandom_range(8, 10);
    endfunction

    task automatic send_weight(logic [W_W-1:0] w, logic last);
        int unsigned gap;
        start                 <= 1'b1;
        in_beat.person_weight <= w;
        in_beat.last_person   <= last;
        do @(posedge i_clk); while (busy);
        beats++;
        if (last) begin
            batches++;
        end
        gap = pick_gap();
        if (gap != 0) begin
            start <= 1'b0;
            idle(gap);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0 || busy);
        @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [W_W-1:0] cap);
        settle();
        idle(4);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        configs++;
    endtask

    task automatic run_batch(int unsigned n, logic [W_W-1:0] cap);
        steady = ($urandom_range(0, 3) == 0);
        for (int unsigned k = 1; k <= n; k++) begin
            send_weight(pick_weight(cap), k == n);
        end
    endtask

    initial begin
        logic [W_W-1:0] cap;
        int unsigned    phase_left;

        idle(6);
        i_rst_n <= 1'b1;
        idle(2);

        send_weight(1, 1'b1);
        send_weight(600, 1'b0);
        send_weight(400, 1'b0);
        send_weight(500, 1'b1);
        send_weight(1000, 1'b0);
        send_weight(1001, 1'b1);

        write_capacity(WEIGHT_MAX);
        send_weight(WEIGHT_MAX, 1'b0);
        send_weight(WEIGHT_MAX, 1'b0);
        send_weight(1, 1'b1);

        write_capacity(1);
        send_weight(1, 1'b0);
        send_weight(1, 1'b1);

        // One weight more than the store holds, so the last beat is dropped.
        write_capacity(3000);
        for (int k = 0; k <= MAX_PERSONS; k++) begin
            send_weight(W_W'($urandom_range(1, 1500)), k == MAX_PERSONS);
        end

        phase_left = 0;
        cap        = 3000;
        while (beats < 100) begin
            if (phase_left == 0) begin
                cap = pick_capacity();
                write_capacity(cap);
                phase_left = $urandom_range(3, 8);
            end else if ($urandom_range(0, 9) == 0) begin
                settle();
            end
            run_batch(pick_size(), cap);
            phase_left--;
        end

        settle();
        idle(20);

        $display("Sent %0d weight beats in %0d batches, one overflowing the store, %s%0d %s",
                 beats, batches, "under ", configs, "capacity settings.");
        $display("Checked %0d ride counts against the prediction.", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("bin_packing_subset_dp test passed");
        end else begin
            $display("bin_packing_subset_dp test failed");
        end
        $finish;
    end

endmodule
